[hdl/bc1_colour_block_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// BC1 decoder assertion macros
// Shared assertion forms for the BC1 colour block decoder. Each macro checks
// on the rising edge of clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BC1_COLOUR_BLOCK_DECODER_CORE_MACROS_SVH
`define BC1_COLOUR_BLOCK_DECODER_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define BC1_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BC1_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bc1cbd_pkg.sv]
// ----------------------------------------------------------------------------
// BC1 decoder package
// Types, constants and helper functions shared by the BC1 decoder modules.
// ----------------------------------------------------------------------------
package bc1cbd_pkg;

	localparam int unsigned TexelCount = 16;
	localparam int unsigned TexelNumW  = 4;
	localparam int unsigned IndexW     = 2;
	localparam int unsigned IndexWordW = TexelCount * IndexW;
	localparam int unsigned ChanW      = 8;
	localparam int unsigned OutChanW   = 16;
	localparam int unsigned InDataW    = 64;
	localparam int unsigned OutDataW   = 72;

	localparam logic [TexelNumW-1:0] LastTexel = 4'd15;
	localparam logic [ChanW-1:0]     AlphaOpaque = 8'hFF;

	// Divide by three as a multiply by 683/2048; exact for inputs below 2048.
	localparam logic [10:0] Div3Mul = 11'd683;
	localparam int unsigned Div3Shift = 11;

	// Configuration register indexes.
	localparam logic [0:0] CfgAllowThree = 1'b0;
	localparam logic [0:0] CfgWideOutput = 1'b1;

	typedef logic [ChanW-1:0] chan_t;
	typedef chan_t [3:0] lane_pal_t;

	// Request that leaves the lane stage for the serializer.
	typedef struct packed {
		logic                  valid;
		logic                  three;
		logic [IndexWordW-1:0] idx;
	} blk_ctl_t;

	function automatic chan_t expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic chan_t expand6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	function automatic chan_t div3(input logic [9:0] x);
		logic [20:0] p;
		p = x * Div3Mul;
		return p[Div3Shift +: ChanW];
	endfunction

endpackage

[hdl/bc1cbd_lane.sv]
// ----------------------------------------------------------------------------
// BC1 decoder channel lane
// Builds the four palette entries of one colour channel from the two
// expanded endpoint values and registers them.
// ----------------------------------------------------------------------------
module bc1cbd_lane (
	input  logic                clk,
	input  logic                en,
	input  logic                three,
	input  bc1cbd_pkg::chan_t   a,
	input  bc1cbd_pkg::chan_t   b,
	output bc1cbd_pkg::lane_pal_t pal_s2
);

	logic [8:0]        sum_ab;
	logic [9:0]        sum_2a_b;
	logic [9:0]        sum_a_2b;
	bc1cbd_pkg::chan_t entry2;
	bc1cbd_pkg::chan_t entry3;

	always_comb begin
		sum_ab   = {1'b0, a} + {1'b0, b};
		sum_2a_b = {1'b0, a, 1'b0} + {2'b00, b};
		sum_a_2b = {2'b00, a} + {1'b0, b, 1'b0};
		if (three) begin
			entry2 = sum_ab[8:1];
			entry3 = '0;
		end else begin
			entry2 = bc1cbd_pkg::div3(sum_2a_b);
			entry3 = bc1cbd_pkg::div3(sum_a_2b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pal_s2 <= {entry3, entry2, b, a};
		end
	end

endmodule

[hdl/bc1cbd_emit.sv]
// ----------------------------------------------------------------------------
// BC1 decoder texel serializer
// Merges the three channel lanes into one palette, walks the sixteen indices
// and drives one texel per cycle, unless m_tready stalls, via a registered output.
// ----------------------------------------------------------------------------
`include "bc1_colour_block_decoder_core_macros.svh"

module bc1cbd_emit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wide,
	input  bc1cbd_pkg::blk_ctl_t               blk,
	input  bc1cbd_pkg::lane_pal_t              pal_red,
	input  bc1cbd_pkg::lane_pal_t              pal_green,
	input  bc1cbd_pkg::lane_pal_t              pal_blue,
	output logic                               load,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// texel_number[3:0], red[19:4], green[35:20], blue[51:36], alpha[67:52]
	output logic [bc1cbd_pkg::OutDataW-1:0]    m_tdata,
	output logic                               m_tlast
);

	bc1cbd_pkg::lane_pal_t                red_q, green_q, blue_q;
	logic                                 three_q;
	logic [bc1cbd_pkg::IndexWordW-1:0]    idx_q;
	logic [bc1cbd_pkg::TexelNumW-1:0]     cnt_q;
	logic                                 busy_q;
	logic                                 out_valid_q;
	logic [bc1cbd_pkg::TexelNumW-1:0]     num_q;
	logic [bc1cbd_pkg::OutChanW-1:0]      red_out_q, green_out_q, blue_out_q, alpha_out_q;
	logic                                 last_q;

	logic                                 emit;
	logic [bc1cbd_pkg::IndexW-1:0]        sel;
	bc1cbd_pkg::chan_t                    r8, g8, b8, a8;

	function automatic logic [bc1cbd_pkg::OutChanW-1:0] scale(
		input bc1cbd_pkg::chan_t v, input logic w);
		return w ? {v, v} : {8'h00, v};
	endfunction

	assign emit = busy_q && (!out_valid_q || m_tready);
	assign load = blk.valid && (!busy_q || (emit && cnt_q == bc1cbd_pkg::LastTexel));

	always_comb begin
		sel = idx_q[{cnt_q, 1'b0} +: bc1cbd_pkg::IndexW];
		r8  = red_q[sel];
		g8  = green_q[sel];
		b8  = blue_q[sel];
		// Only the fourth entry of a three-colour block is transparent.
		a8  = (three_q && sel == 2'd3) ? '0 : bc1cbd_pkg::AlphaOpaque;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bc1cbd_pkg::LastTexel) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= pal_red;
			green_q <= pal_green;
			blue_q  <= pal_blue;
			three_q <= blk.three;
			idx_q   <= blk.idx;
		end
		if (emit) begin
			num_q       <= cnt_q;
			red_out_q   <= scale(r8, wide);
			green_out_q <= scale(g8, wide);
			blue_out_q  <= scale(b8, wide);
			alpha_out_q <= scale(a8, wide);
			last_q      <= (cnt_q == bc1cbd_pkg::LastTexel);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, alpha_out_q, blue_out_q, green_out_q, red_out_q, num_q};
	assign m_tlast  = last_q;

	`BC1_ASSERT_NOW(a_last_on_final, out_valid_q, last_q == (num_q == bc1cbd_pkg::LastTexel), "tlast does not match texel 15")
	`BC1_ASSERT_NEXT(a_emit_fills_out, emit, out_valid_q && num_q == $past(cnt_q), "emitted texel not in output register")
	`BC1_ASSERT_NEXT(a_stall_holds_cnt, busy_q && !emit && !load, $stable(cnt_q) && busy_q, "texel counter moved during a stall")
	`BC1_ASSERT_NEXT(a_mid_block_busy, emit && cnt_q != bc1cbd_pkg::LastTexel, busy_q, "block ended before texel 15")

endmodule

[hdl/bc1_colour_block_decoder_core.sv]
// ----------------------------------------------------------------------------
// BC1 colour block decoder
// Decodes one 64-bit BC1 colour block into sixteen RGBA texels.
//
//   channel   direction  accept when               payload
//   s_*       in         s_tvalid & s_tready       tdata: block (e0, e1, indices)
//   m_*       out        m_tvalid & m_tready       tdata: texel, tlast: texel 15
//   cfg_*     in         cfg_we                    cfg_index, cfg_data
//
// Throughput is one texel per cycle while m_tready stays high; the texel
// serializer that walks the sixteen indices sets that rate.
// An accepted block moves through stage one and stage two (the lane registers)
// into the serializer; its texels pass the output register to reach m_tdata.
// Two further blocks can be taken while one is being emitted; an output
// stall holds the serializer, then the lane stage, then s_tready.
// arst_n clears all control state; allow_three_colour resets to 1.
// ----------------------------------------------------------------------------
module bc1_colour_block_decoder_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// endpoint_zero[15:0], endpoint_one[31:16], index_word[63:32]
	input  logic [bc1cbd_pkg::InDataW-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// texel_number[3:0], red[19:4], green[35:20], blue[51:36], alpha[67:52]
	output logic [bc1cbd_pkg::OutDataW-1:0]  m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [0:0]                       cfg_data
);

	logic                              allow_three_q;
	logic                              wide_q;

	logic                              valid_s1;
	logic                              three_s1;
	logic [15:0]                       e0_s1, e1_s1;
	logic [bc1cbd_pkg::IndexWordW-1:0] idx_s1;

	logic                              valid_s2;
	logic                              three_s2;
	logic [bc1cbd_pkg::IndexWordW-1:0] idx_s2;

	logic                              adv_s2;
	logic                              load;
	bc1cbd_pkg::blk_ctl_t              blk_s2;
	bc1cbd_pkg::lane_pal_t             pal_red_s2, pal_green_s2, pal_blue_s2;

	logic [15:0]                       in_e0, in_e1;

	assign in_e0 = s_tdata[15:0];
	assign in_e1 = s_tdata[31:16];

	// Stage two frees when the serializer takes its block.
	assign adv_s2   = valid_s1 && (!valid_s2 || load);
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_three_q <= 1'b1;
			wide_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bc1cbd_pkg::CfgAllowThree: allow_three_q <= cfg_data[0];
				bc1cbd_pkg::CfgWideOutput: wide_q        <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (load) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			e0_s1    <= in_e0;
			e1_s1    <= in_e1;
			idx_s1   <= s_tdata[63:32];
			three_s1 <= allow_three_q && (in_e0 <= in_e1);
		end
		if (adv_s2) begin
			three_s2 <= three_s1;
			idx_s2   <= idx_s1;
		end
	end

	bc1cbd_lane u_lane_red (
		.clk    (clk),
		.en     (adv_s2),
		.three  (three_s1),
		.a      (bc1cbd_pkg::expand5(e0_s1[15:11])),
		.b      (bc1cbd_pkg::expand5(e1_s1[15:11])),
		.pal_s2 (pal_red_s2)
	);

	bc1cbd_lane u_lane_green (
		.clk    (clk),
		.en     (adv_s2),
		.three  (three_s1),
		.a      (bc1cbd_pkg::expand6(e0_s1[10:5])),
		.b      (bc1cbd_pkg::expand6(e1_s1[10:5])),
		.pal_s2 (pal_green_s2)
	);

	bc1cbd_lane u_lane_blue (
		.clk    (clk),
		.en     (adv_s2),
		.three  (three_s1),
		.a      (bc1cbd_pkg::expand5(e0_s1[4:0])),
		.b      (bc1cbd_pkg::expand5(e1_s1[4:0])),
		.pal_s2 (pal_blue_s2)
	);

	always_comb begin
		blk_s2.valid = valid_s2;
		blk_s2.three = three_s2;
		blk_s2.idx   = idx_s2;
	end

	bc1cbd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.wide      (wide_q),
		.blk       (blk_s2),
		.pal_red   (pal_red_s2),
		.pal_green (pal_green_s2),
		.pal_blue  (pal_blue_s2),
		.load      (load),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

[tb/bc1_texel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1 texel checker
// Watches the block, texel and configuration channels of the BC1 decoder.
// Every accepted block is decoded here into its sixteen texels, which are
// queued and compared field by field with the texels the decoder emits.
// ----------------------------------------------------------------------------
module bc1_texel_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// endpoint_zero[15:0], endpoint_one[31:16], index_word[63:32]
	input  logic [bc1cbd_pkg::InDataW-1:0]   s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// texel_number[3:0], red[19:4], green[35:20], blue[51:36], alpha[67:52]
	input  logic [bc1cbd_pkg::OutDataW-1:0]  m_tdata,
	input  logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [0:0]                       cfg_data,
	output int unsigned                      fail_count,
	output int unsigned                      pending
);

	typedef struct packed {
		logic [bc1cbd_pkg::TexelNumW-1:0] num;
		logic [3:0][15:0]                 chan;   // red, green, blue, alpha from index 0 up
		logic                             last;
	} texel_t;

	texel_t      texel_q[$];
	logic        allow_three;
	logic        wide;
	int unsigned mismatches = 0;

	assign fail_count = mismatches;

	// Widens a 5- or 6-bit channel to 8 bits by repeating its top bits.
	function automatic int unsigned widen(input int unsigned v, input int unsigned bits);
		return ((v << (8 - bits)) | (v >> (2 * bits - 8))) & 8'hFF;
	endfunction

	function automatic void decode_block(input logic [15:0] e0, input logic [15:0] e1,
			input logic [31:0] idx);
		int unsigned lo[3];
		int unsigned hi[3];
		int unsigned pal[4][4];
		int unsigned sel;
		logic        three;
		texel_t      t;
		lo[0] = widen(32'(e0[15:11]), 5);
		lo[1] = widen(32'(e0[10:5]), 6);
		lo[2] = widen(32'(e0[4:0]), 5);
		hi[0] = widen(32'(e1[15:11]), 5);
		hi[1] = widen(32'(e1[10:5]), 6);
		hi[2] = widen(32'(e1[4:0]), 5);
		three = allow_three && (e0 <= e1);
		for (int c = 0; c < 3; c++) begin
			pal[0][c] = lo[c];
			pal[1][c] = hi[c];
			if (three) begin
				pal[2][c] = (lo[c] + hi[c]) / 2;
				pal[3][c] = 0;
			end else begin
				pal[2][c] = (2 * lo[c] + hi[c]) / 3;
				pal[3][c] = (lo[c] + 2 * hi[c]) / 3;
			end
		end
		pal[0][3] = 255;
		pal[1][3] = 255;
		pal[2][3] = 255;
		pal[3][3] = three ? 0 : 255;
		for (int i = 0; i < bc1cbd_pkg::TexelCount; i++) begin
			sel = 32'(idx[2 * i +: 2]);
			t.num = i[bc1cbd_pkg::TexelNumW-1:0];
			for (int c = 0; c < 4; c++)
				t.chan[c] = 16'(wide ? pal[sel][c] * 257 : pal[sel][c]);
			t.last = (i == bc1cbd_pkg::TexelCount - 1);
			texel_q.push_back(t);
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		texel_t want;
		if (!arst_n) begin
			allow_three = 1'b1;
			wide = 1'b0;
			texel_q.delete();
			pending <= 0;
		end else begin
			// A texel can never belong to a block accepted at the same edge.
			if (m_tvalid && m_tready) begin
				if (texel_q.size() == 0) begin
					$error("texel: unexpected texel %0d, none pending", m_tdata[3:0]);
					mismatches++;
				end else begin
					want = texel_q.pop_front();
					check_field("texel_number", 32'(want.num), 32'(m_tdata[3:0]));
					check_field("red", 32'(want.chan[0]), 32'(m_tdata[4 +: 16]));
					check_field("green", 32'(want.chan[1]), 32'(m_tdata[20 +: 16]));
					check_field("blue", 32'(want.chan[2]), 32'(m_tdata[36 +: 16]));
					check_field("alpha", 32'(want.chan[3]), 32'(m_tdata[52 +: 16]));
					check_field("last_texel", 32'(want.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				decode_block(s_tdata[15:0], s_tdata[31:16], s_tdata[63:32]);
			if (cfg_we) begin
				if (cfg_index == bc1cbd_pkg::CfgAllowThree)
					allow_three = cfg_data[0];
				else if (cfg_index == bc1cbd_pkg::CfgWideOutput)
					wide = cfg_data[0];
			end
			pending <= texel_q.size();
		end
	end

endmodule

[tb/bc1_colour_block_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1 colour block decoder testbench
// Feeds directed and random BC1 colour blocks through the decoder under all
// four register settings, with random gaps on the block side and random
// stalls on the texel side. The checker beside the decoder predicts every
// texel; this module drives the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module bc1_colour_block_decoder_core_tb;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned DrainCycles = 8;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [bc1cbd_pkg::InDataW-1:0]      s_tdata = '0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [bc1cbd_pkg::OutDataW-1:0]     m_tdata;
	logic                                m_tlast;
	logic                                cfg_we = 1'b0;
	logic [0:0]                          cfg_index = '0;
	logic [0:0]                          cfg_data = '0;
	int unsigned                         fail_count;
	int unsigned                         pending;
	int unsigned                         cycles = 0;
	logic                                src_rush = 1'b0;
	logic                                sink_rush = 1'b0;

	bc1_colour_block_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bc1_texel_checker texel_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("bc1_colour_block_decoder_core: mismatch");
			$finish;
		end
	end

	// Texel sink: a random stall before each texel, none while rushing.
	initial begin
		int unsigned gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = sink_rush ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_block(input logic [15:0] e0, input logic [15:0] e1,
			input logic [31:0] idx);
		int unsigned gap;
		gap = src_rush ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {idx, e1, e0};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_block();
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] tmp;
		logic [31:0] idx;
		a = 16'($urandom);
		b = 16'($urandom);
		idx = $urandom;
		case ($urandom_range(0, 5))
			0: b = a;
			1: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			2, 3: begin
				if (a > b) begin
					tmp = a;
					a = b;
					b = tmp;
				end
			end
			default: ;
		endcase
		send_block(a, b, idx);
	endtask

	// Lets every pending texel drain before the registers are touched.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [0:0] sel, input logic val);
		cfg_index <= sel;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic allow_seq[4];
		logic wide_seq[4];
		allow_seq = '{1'b0, 1'b1, 1'b0, 1'b1};
		wide_seq = '{1'b0, 1'b1, 1'b1, 1'b0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: three-colour mode allowed, 8-bit channels.
		send_block(16'h0000, 16'h0000, 32'h0000_0000);
		send_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
		send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
		send_block(16'hF800, 16'h07E0, 32'h1B1B_1B1B);
		send_block(16'h001F, 16'hF800, 32'hAAAA_AAAA);
		send_block(16'h1234, 16'h1235, 32'h5555_5555);
		send_block(16'h1235, 16'h1234, 32'hFFFF_FFFF);
		send_block(16'h8000, 16'h7FFF, 32'hC639_9C63);

		settle();
		write_cfg(bc1cbd_pkg::CfgWideOutput, 1'b1);
		send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
		send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);

		// Equal endpoints must now decode in four-colour mode.
		settle();
		write_cfg(bc1cbd_pkg::CfgAllowThree, 1'b0);
		send_block(16'h0000, 16'h0000, 32'hE4E4_E4E4);
		send_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);

		for (int p = 0; p < 4; p++) begin
			settle();
			write_cfg(bc1cbd_pkg::CfgAllowThree, allow_seq[p]);
			write_cfg(bc1cbd_pkg::CfgWideOutput, wide_seq[p]);
			src_rush = (p == 1) || (p == 3);
			sink_rush = (p == 1) || (p == 2);
			repeat (50) random_block();
		end

		settle();
		if (fail_count == 0) begin
			$display("bc1_colour_block_decoder_core: match");
		end else begin
			$display("bc1_colour_block_decoder_core: mismatch");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/bc1cbd_pkg.sv
hdl/bc1cbd_lane.sv
hdl/bc1cbd_emit.sv
hdl/bc1_colour_block_decoder_core.sv
tb/bc1_texel_checker.sv
tb/bc1_colour_block_decoder_core_tb.sv
